// File: design/assert_macros.svh
// Assertion macros used by the classifier design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on the rising clock edge, switched off while reset is low.
`define BPSC_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent assertion on the rising clock edge that also holds during reset.
`define BPSC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: design/bpsc_pkg.sv
// Shared constants and codes of the box and plane side classifier.
package bpsc_pkg;

  // Default widths of the coordinate fields and the normal fraction.
  localparam int unsigned COORD_WIDTH_DEF      = 32;
  localparam int unsigned NORMAL_FRAC_BITS_DEF = 14;

  // The normal components are always 16-bit signed words.
  localparam int unsigned NORMAL_WIDTH = 16;

  // Widths of the plane kind, normal sign and side code fields.
  localparam int unsigned KIND_WIDTH  = 3;
  localparam int unsigned SIGNS_WIDTH = 3;
  localparam int unsigned SIDE_WIDTH  = 2;

  // Plane kinds that name an axial plane; every other kind is a general plane.
  localparam logic [KIND_WIDTH-1:0] KIND_AXIAL_X = 3'd0;
  localparam logic [KIND_WIDTH-1:0] KIND_AXIAL_Y = 3'd1;
  localparam logic [KIND_WIDTH-1:0] KIND_AXIAL_Z = 3'd2;

  // Side codes of the result.
  localparam logic [SIDE_WIDTH-1:0] SIDE_FRONT = 2'd1;
  localparam logic [SIDE_WIDTH-1:0] SIDE_BACK  = 2'd2;
  localparam logic [SIDE_WIDTH-1:0] SIDE_CROSS = 2'd3;

endpackage

// File: design/bpsc_if.sv
// Valid and ready channels that carry the test words and the side results.

// Input channel: one box and one plane per word.
interface bpsc_in_if
  import bpsc_pkg::*;
#(
  parameter int unsigned COORD_WIDTH = COORD_WIDTH_DEF
);
  logic                           valid;
  logic                           ready;
  logic signed [COORD_WIDTH-1:0]  box_min_x;
  logic signed [COORD_WIDTH-1:0]  box_min_y;
  logic signed [COORD_WIDTH-1:0]  box_min_z;
  logic signed [COORD_WIDTH-1:0]  box_max_x;
  logic signed [COORD_WIDTH-1:0]  box_max_y;
  logic signed [COORD_WIDTH-1:0]  box_max_z;
  logic signed [NORMAL_WIDTH-1:0] normal_x;
  logic signed [NORMAL_WIDTH-1:0] normal_y;
  logic signed [NORMAL_WIDTH-1:0] normal_z;
  logic signed [COORD_WIDTH-1:0]  plane_distance;
  logic        [KIND_WIDTH-1:0]   plane_kind;
  logic        [SIGNS_WIDTH-1:0]  normal_signs;

  modport source (
    output valid, box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
           normal_x, normal_y, normal_z, plane_distance, plane_kind, normal_signs,
    input  ready
  );

  modport sink (
    input  valid, box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
           normal_x, normal_y, normal_z, plane_distance, plane_kind, normal_signs,
    output ready
  );
endinterface

// Output channel: one side mask per word.
interface bpsc_out_if
  import bpsc_pkg::*;
;
  logic                  valid;
  logic                  ready;
  logic [SIDE_WIDTH-1:0] side_mask;

  modport source (
    output valid, side_mask,
    input  ready
  );

  modport sink (
    input  valid, side_mask,
    output ready
  );
endinterface

// File: design/box_plane_side_classifier.sv
// Top level of the box and plane side classifier pipeline.

// The block takes one word per clock cycle, as long as the output side does
// not stall, and returns one side mask per word, in the order they are taken.
// The four register stages are operand selection with the axial compare, the
// six normal-by-corner multiplications, the two three-term sums with the
// shifted distance, and the final compares into the output register. All
// stages advance together: the input is ready whenever the output register is
// empty or its word is being taken, so a full pipeline keeps one word per
// cycle flowing. The block holds no state beyond the words in flight.
`include "assert_macros.svh"

module box_plane_side_classifier
  import bpsc_pkg::*;
#(
  parameter int unsigned COORD_WIDTH      = COORD_WIDTH_DEF,
  parameter int unsigned NORMAL_FRAC_BITS = NORMAL_FRAC_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  bpsc_in_if.sink     in_i,
  bpsc_out_if.source  out_o
);

  localparam int unsigned STAGES = 4;
  localparam int unsigned PROD_W = COORD_WIDTH + NORMAL_WIDTH;
  localparam int unsigned SUM_W  = PROD_W + 2;
  localparam int unsigned DSH_W  = COORD_WIDTH + NORMAL_FRAC_BITS;
  localparam int unsigned CMP_W  = ((SUM_W > DSH_W) ? SUM_W : DSH_W) + 1;

  // Stage valid bits; the last one belongs to the output register.
  logic [STAGES-1:0] valid_q;
  logic              adv;

  // The whole pipeline moves when the output register can take a new word.
  assign adv        = !valid_q[STAGES-1] || out_o.ready;
  assign in_i.ready = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (adv) begin
      valid_q <= {valid_q[STAGES-2:0], in_i.valid};
    end
  end

  // Stage 1: pick the far and near corners and do the axial compare.
  logic signed [COORD_WIDTH-1:0]  far_d [3];
  logic signed [COORD_WIDTH-1:0]  near_d [3];
  logic signed [COORD_WIDTH-1:0]  axis_min;
  logic signed [COORD_WIDTH-1:0]  axis_max;
  logic                           axial_d;
  logic        [SIDE_WIDTH-1:0]   axial_side_d;

  logic signed [COORD_WIDTH-1:0]  s1_far_q [3];
  logic signed [COORD_WIDTH-1:0]  s1_near_q [3];
  logic signed [NORMAL_WIDTH-1:0] s1_normal_q [3];
  logic signed [COORD_WIDTH-1:0]  s1_dist_q;
  logic                           s1_axial_q;
  logic        [SIDE_WIDTH-1:0]   s1_side_q;

  always_comb begin
    logic signed [COORD_WIDTH-1:0] mn [3];
    logic signed [COORD_WIDTH-1:0] mx [3];
    mn[0] = in_i.box_min_x;
    mn[1] = in_i.box_min_y;
    mn[2] = in_i.box_min_z;
    mx[0] = in_i.box_max_x;
    mx[1] = in_i.box_max_y;
    mx[2] = in_i.box_max_z;
    // A set sign bit means the minimum coordinate lies farthest along the normal.
    for (int k = 0; k < 3; k++) begin
      far_d[k]  = in_i.normal_signs[k] ? mn[k] : mx[k];
      near_d[k] = in_i.normal_signs[k] ? mx[k] : mn[k];
    end
    case (in_i.plane_kind)
      KIND_AXIAL_Y: begin
        axis_min = mn[1];
        axis_max = mx[1];
      end
      KIND_AXIAL_Z: begin
        axis_min = mn[2];
        axis_max = mx[2];
      end
      default: begin
        axis_min = mn[0];
        axis_max = mx[0];
      end
    endcase
    axial_d = in_i.plane_kind inside {KIND_AXIAL_X, KIND_AXIAL_Y, KIND_AXIAL_Z};
    if (in_i.plane_distance <= axis_min) begin
      axial_side_d = SIDE_FRONT;
    end else if (in_i.plane_distance >= axis_max) begin
      axial_side_d = SIDE_BACK;
    end else begin
      axial_side_d = SIDE_CROSS;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_far_q       <= far_d;
      s1_near_q      <= near_d;
      s1_normal_q[0] <= in_i.normal_x;
      s1_normal_q[1] <= in_i.normal_y;
      s1_normal_q[2] <= in_i.normal_z;
      s1_dist_q      <= in_i.plane_distance;
      s1_axial_q     <= axial_d;
      s1_side_q      <= axial_side_d;
    end
  end

  // Stage 2: exact products of each normal component with both corners.
  logic signed [PROD_W-1:0]      prod_far_d [3];
  logic signed [PROD_W-1:0]      prod_near_d [3];
  logic signed [PROD_W-1:0]      s2_far_q [3];
  logic signed [PROD_W-1:0]      s2_near_q [3];
  logic signed [COORD_WIDTH-1:0] s2_dist_q;
  logic                          s2_axial_q;
  logic        [SIDE_WIDTH-1:0]  s2_side_q;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      prod_far_d[k]  = PROD_W'(s1_normal_q[k]) * PROD_W'(s1_far_q[k]);
      prod_near_d[k] = PROD_W'(s1_normal_q[k]) * PROD_W'(s1_near_q[k]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_far_q   <= prod_far_d;
      s2_near_q  <= prod_near_d;
      s2_dist_q  <= s1_dist_q;
      s2_axial_q <= s1_axial_q;
      s2_side_q  <= s1_side_q;
    end
  end

  // Stage 3: dot products and the distance scaled to the product fraction.
  logic signed [SUM_W-1:0]      sum_far_d;
  logic signed [SUM_W-1:0]      sum_near_d;
  logic signed [DSH_W-1:0]      dist_shift_d;
  logic signed [SUM_W-1:0]      s3_far_q;
  logic signed [SUM_W-1:0]      s3_near_q;
  logic signed [DSH_W-1:0]      s3_dist_q;
  logic                         s3_axial_q;
  logic        [SIDE_WIDTH-1:0] s3_side_q;

  assign sum_far_d    = SUM_W'(s2_far_q[0]) + SUM_W'(s2_far_q[1]) + SUM_W'(s2_far_q[2]);
  assign sum_near_d   = SUM_W'(s2_near_q[0]) + SUM_W'(s2_near_q[1]) + SUM_W'(s2_near_q[2]);
  assign dist_shift_d = DSH_W'(s2_dist_q) <<< NORMAL_FRAC_BITS;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s3_far_q   <= sum_far_d;
      s3_near_q  <= sum_near_d;
      s3_dist_q  <= dist_shift_d;
      s3_axial_q <= s2_axial_q;
      s3_side_q  <= s2_side_q;
    end
  end

  // Stage 4: compare both dot products with the distance, or pass the axial side, into the output word.
  logic signed [CMP_W-1:0]      cmp_far;
  logic signed [CMP_W-1:0]      cmp_near;
  logic signed [CMP_W-1:0]      cmp_dist;
  logic        [SIDE_WIDTH-1:0] side_d;
  logic        [SIDE_WIDTH-1:0] side_q;

  assign cmp_far  = CMP_W'(s3_far_q);
  assign cmp_near = CMP_W'(s3_near_q);
  assign cmp_dist = CMP_W'(s3_dist_q);

  always_comb begin
    if (s3_axial_q) begin
      side_d = s3_side_q;
    end else begin
      side_d    = '0;
      side_d[0] = cmp_far >= cmp_dist;
      side_d[1] = cmp_near < cmp_dist;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      side_q <= side_d;
    end
  end

  assign out_o.valid     = valid_q[STAGES-1];
  assign out_o.side_mask = side_q;

  // Checks on the stage control.
  `BPSC_ASSERT(a_stall_holds_valids, clk_i, rst_ni, !adv |=> $stable(valid_q),
               "stage valid bits changed during a stall")
  `BPSC_ASSERT(a_word_moves_on, clk_i, rst_ni,
               adv && valid_q[STAGES-2] |=> valid_q[STAGES-1],
               "a word was lost on its way into the output register")
  `BPSC_ASSERT(a_axial_never_empty, clk_i, rst_ni,
               adv && valid_q[STAGES-2] && s3_axial_q |=> side_q != '0,
               "axial plane test gave an empty side mask")
  `BPSC_ASSERT_ALWAYS(a_reset_empties, clk_i, !rst_ni |-> valid_q == '0,
                      "pipeline holds words during reset")

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench of the box and plane side classifier: directed table and random words.
module tb_top;
  import bpsc_pkg::*;

  localparam int unsigned CW = COORD_WIDTH_DEF;
  localparam int unsigned FB = NORMAL_FRAC_BITS_DEF;
  localparam real CLK_PERIOD = 4.0;

  // Side mask for a box that touches neither side, seen with inconsistent sign bits.
  localparam logic [SIDE_WIDTH-1:0] SIDE_NONE = 2'd0;

  // Plane kinds outside the axial range, all treated as general planes.
  localparam logic [KIND_WIDTH-1:0] KIND_GENERAL_0 = 3'd3;
  localparam logic [KIND_WIDTH-1:0] KIND_GENERAL_1 = 3'd4;
  localparam logic [KIND_WIDTH-1:0] KIND_GENERAL_2 = 3'd5;
  localparam logic [KIND_WIDTH-1:0] KIND_GENERAL_3 = 3'd6;
  localparam logic [KIND_WIDTH-1:0] KIND_GENERAL_4 = 3'd7;

  localparam logic signed [CW-1:0] C_MIN = {1'b1, {(CW-1){1'b0}}};
  localparam logic signed [CW-1:0] C_MAX = {1'b0, {(CW-1){1'b1}}};

  localparam int N_RANDOM     = 1530;
  localparam int QUIET_TAIL   = 150;
  localparam int LONG_HOLD    = 400;
  localparam int HOLD_AFTER   = 60;
  localparam int DRAIN_CYCLES = 12;
  localparam int STALL_LIMIT  = 5000;

  typedef struct {
    logic signed [CW-1:0]           box_min_x;
    logic signed [CW-1:0]           box_min_y;
    logic signed [CW-1:0]           box_min_z;
    logic signed [CW-1:0]           box_max_x;
    logic signed [CW-1:0]           box_max_y;
    logic signed [CW-1:0]           box_max_z;
    logic signed [NORMAL_WIDTH-1:0] normal_x;
    logic signed [NORMAL_WIDTH-1:0] normal_y;
    logic signed [NORMAL_WIDTH-1:0] normal_z;
    logic signed [CW-1:0]           plane_distance;
    logic        [KIND_WIDTH-1:0]   plane_kind;
    logic        [SIGNS_WIDTH-1:0]  normal_signs;
  } box_plane_word_t;

  typedef struct {
    box_plane_word_t       w;
    bit                    typed;
    logic [SIDE_WIDTH-1:0] side;
  } side_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  bpsc_in_if #(.COORD_WIDTH(CW)) in_ch ();
  bpsc_out_if                    out_ch ();

  box_plane_side_classifier #(
    .COORD_WIDTH      (CW),
    .NORMAL_FRAC_BITS (FB)
  ) u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  // Free-running clock.
  always #(CLK_PERIOD / 2.0) clk_i = ~clk_i;

  logic [SIDE_WIDTH-1:0] expected_sides[$];
  side_row_t             side_rows[$];
  int                    fail_count     = 0;
  int                    words_taken    = 0;
  int                    quiet_cycles   = 0;
  bit                    quiet_tail     = 1'b0;
  bit                    long_hold_done = 1'b0;

  task automatic report_mismatch(input string what, input logic [SIDE_WIDTH-1:0] got,
                                 input logic [SIDE_WIDTH-1:0] want);
    $display("mismatch at %0t: %s, side mask %0d, expected %0d", $realtime, what, got, want);
    fail_count++;
  endtask

  function automatic box_plane_word_t box_word(
    input logic signed [CW-1:0]           mnx, mny, mnz, mxx, mxy, mxz,
    input logic signed [NORMAL_WIDTH-1:0] nx, ny, nz,
    input logic signed [CW-1:0]           d,
    input logic [KIND_WIDTH-1:0]          kind,
    input logic [SIGNS_WIDTH-1:0]         signs);
    box_plane_word_t w;
    w.box_min_x      = mnx;
    w.box_min_y      = mny;
    w.box_min_z      = mnz;
    w.box_max_x      = mxx;
    w.box_max_y      = mxy;
    w.box_max_z      = mxz;
    w.normal_x       = nx;
    w.normal_y       = ny;
    w.normal_z       = nz;
    w.plane_distance = d;
    w.plane_kind     = kind;
    w.normal_signs   = signs;
    return w;
  endfunction

  task automatic add_row(input box_plane_word_t w, input bit typed,
                         input logic [SIDE_WIDTH-1:0] side);
    side_row_t r;
    r.w     = w;
    r.typed = typed;
    r.side  = side;
    side_rows.push_back(r);
  endtask

  // Far and near corner dot products, exact in 64 bits.
  function automatic void corner_dots(input box_plane_word_t w, output longint far,
                                      output longint near);
    logic signed [CW-1:0]           mn[3];
    logic signed [CW-1:0]           mx[3];
    logic signed [NORMAL_WIDTH-1:0] nv[3];
    mn   = '{w.box_min_x, w.box_min_y, w.box_min_z};
    mx   = '{w.box_max_x, w.box_max_y, w.box_max_z};
    nv   = '{w.normal_x, w.normal_y, w.normal_z};
    far  = 0;
    near = 0;
    for (int k = 0; k < 3; k++) begin
      if (w.normal_signs[k]) begin
        far  += longint'(nv[k]) * longint'(mn[k]);
        near += longint'(nv[k]) * longint'(mx[k]);
      end else begin
        far  += longint'(nv[k]) * longint'(mx[k]);
        near += longint'(nv[k]) * longint'(mn[k]);
      end
    end
  endfunction

  // Side mask that the classifier should give for one word.
  function automatic logic [SIDE_WIDTH-1:0] predict_side(input box_plane_word_t w);
    logic signed [CW-1:0]  lo;
    logic signed [CW-1:0]  hi;
    longint                far;
    longint                near;
    longint                d_scaled;
    logic [SIDE_WIDTH-1:0] side;
    if (w.plane_kind == KIND_AXIAL_X || w.plane_kind == KIND_AXIAL_Y ||
        w.plane_kind == KIND_AXIAL_Z) begin
      case (w.plane_kind)
        KIND_AXIAL_X: begin
          lo = w.box_min_x;
          hi = w.box_max_x;
        end
        KIND_AXIAL_Y: begin
          lo = w.box_min_y;
          hi = w.box_max_y;
        end
        default: begin
          lo = w.box_min_z;
          hi = w.box_max_z;
        end
      endcase
      if (w.plane_distance <= lo) begin
        side = SIDE_FRONT;
      end else if (w.plane_distance >= hi) begin
        side = SIDE_BACK;
      end else begin
        side = SIDE_CROSS;
      end
    end else begin
      corner_dots(w, far, near);
      d_scaled = longint'(w.plane_distance) <<< FB;
      side     = SIDE_NONE;
      if (far >= d_scaled) side |= SIDE_FRONT;
      if (near < d_scaled) side |= SIDE_BACK;
    end
    return side;
  endfunction

  function automatic logic signed [CW-1:0] clamp_coord(input longint v);
    if (v > longint'(C_MAX)) return C_MAX;
    if (v < longint'(C_MIN)) return C_MIN;
    return v[CW-1:0];
  endfunction

  function automatic logic signed [CW-1:0] rand_coord();
    logic signed [CW-1:0] v;
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0:       v = C_MIN;
          1:       v = C_MAX;
          2:       v = '0;
          default: v = '1;
        endcase
      end
      1, 2, 3: v = CW'($urandom);
      default: begin
        v = CW'($urandom_range(0, 32'h1F_FFFF));
        v = v - 32'sd1048576;
      end
    endcase
    return v;
  endfunction

  function automatic logic signed [NORMAL_WIDTH-1:0] rand_normal();
    logic signed [NORMAL_WIDTH-1:0] v;
    int                             t;
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0:       v = 16'sh8000;
          1:       v = 16'sh7FFF;
          2:       v = '0;
          default: v = '1;
        endcase
      end
      1, 2, 3: v = NORMAL_WIDTH'($urandom);
      default: begin
        t = $urandom_range(0, 32768);
        v = NORMAL_WIDTH'(t - 16384);
      end
    endcase
    return v;
  endfunction

  // Random word: mostly ordered boxes with consistent signs and a distance near a
  // decision boundary, the rest broken signs or plain noise.
  task automatic gen_test_word(output box_plane_word_t w);
    logic signed [CW-1:0]           mn[3];
    logic signed [CW-1:0]           mx[3];
    logic signed [CW-1:0]           t;
    logic signed [NORMAL_WIDTH-1:0] nv[3];
    longint                         far;
    longint                         near;
    longint                         dv;
    int                             shape;
    int                             axis;
    shape = $urandom_range(0, 9);
    for (int k = 0; k < 3; k++) begin
      mn[k] = rand_coord();
      mx[k] = rand_coord();
      if (shape != 0 && mn[k] > mx[k]) begin
        t     = mn[k];
        mn[k] = mx[k];
        mx[k] = t;
      end
      nv[k] = rand_normal();
    end
    w = box_word(mn[0], mn[1], mn[2], mx[0], mx[1], mx[2], nv[0], nv[1], nv[2],
                 rand_coord(), KIND_AXIAL_X, {nv[2][NORMAL_WIDTH-1], nv[1][NORMAL_WIDTH-1],
                 nv[0][NORMAL_WIDTH-1]});
    if (shape == 0) begin
      w.plane_kind = KIND_WIDTH'($urandom_range(KIND_AXIAL_X, KIND_GENERAL_4));
    end else if ($urandom_range(0, 4) < 2) begin
      w.plane_kind = KIND_WIDTH'($urandom_range(KIND_AXIAL_X, KIND_AXIAL_Z));
    end else begin
      w.plane_kind = KIND_WIDTH'($urandom_range(KIND_GENERAL_0, KIND_GENERAL_4));
    end
    if (shape <= 1) w.normal_signs = SIGNS_WIDTH'($urandom);

    // Aim the distance at a corner, a midpoint or just past a boundary.
    if (w.plane_kind <= KIND_AXIAL_Z) begin
      axis = int'(w.plane_kind);
      case ($urandom_range(0, 4))
        0:       dv = longint'(mn[axis]);
        1:       dv = longint'(mx[axis]);
        2:       dv = (longint'(mn[axis]) + longint'(mx[axis])) / 2;
        3:       dv = longint'(mx[axis]) + 1;
        default: dv = longint'(w.plane_distance);
      endcase
    end else begin
      corner_dots(w, far, near);
      case ($urandom_range(0, 4))
        0:       dv = ((far + near) / 2) >>> FB;
        1:       dv = far >>> FB;
        2:       dv = near >>> FB;
        3:       dv = (near >>> FB) + 1;
        default: dv = longint'(w.plane_distance);
      endcase
    end
    w.plane_distance = clamp_coord(dv);
  endtask

  // Offers one word, sometimes after a random idle burst, and records its side mask once taken.
  task automatic send_word(input box_plane_word_t w, input logic [SIDE_WIDTH-1:0] side);
    if (!quiet_tail && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
    in_ch.valid          <= 1'b1;
    in_ch.box_min_x      <= w.box_min_x;
    in_ch.box_min_y      <= w.box_min_y;
    in_ch.box_min_z      <= w.box_min_z;
    in_ch.box_max_x      <= w.box_max_x;
    in_ch.box_max_y      <= w.box_max_y;
    in_ch.box_max_z      <= w.box_max_z;
    in_ch.normal_x       <= w.normal_x;
    in_ch.normal_y       <= w.normal_y;
    in_ch.normal_z       <= w.normal_z;
    in_ch.plane_distance <= w.plane_distance;
    in_ch.plane_kind     <= w.plane_kind;
    in_ch.normal_signs   <= w.normal_signs;
    do @(posedge clk_i); while (!in_ch.ready);
    expected_sides.push_back(side);
    words_taken++;
  endtask

  // Sender: reset, the directed table, the random words, then the drain.
  initial begin
    box_plane_word_t w;
    in_ch.valid          = 1'b0;
    in_ch.box_min_x      = '0;
    in_ch.box_min_y      = '0;
    in_ch.box_min_z      = '0;
    in_ch.box_max_x      = '0;
    in_ch.box_max_y      = '0;
    in_ch.box_max_z      = '0;
    in_ch.normal_x       = '0;
    in_ch.normal_y       = '0;
    in_ch.normal_z       = '0;
    in_ch.plane_distance = '0;
    in_ch.plane_kind     = '0;
    in_ch.normal_signs   = '0;
    rst_ni               = 1'b0;

    // Axial planes: on the min face, on the max face, inside, at the range extremes.
    add_row(box_word(0, 0, 0, 10, 0, 0, 0, 0, 0, 0, KIND_AXIAL_X, 3'b000), 1'b1, SIDE_FRONT);
    add_row(box_word(0, 0, 0, 10, 0, 0, 0, 0, 0, 10, KIND_AXIAL_X, 3'b000), 1'b1, SIDE_BACK);
    add_row(box_word(0, 0, 0, 10, 0, 0, 0, 0, 0, 5, KIND_AXIAL_X, 3'b000), 1'b1, SIDE_CROSS);
    add_row(box_word(0, C_MIN, 0, 0, C_MAX, 0, 0, 0, 0, C_MIN, KIND_AXIAL_Y, 3'b000),
            1'b1, SIDE_FRONT);
    add_row(box_word(0, C_MIN, 0, 0, C_MAX, 0, 0, 0, 0, C_MAX, KIND_AXIAL_Y, 3'b000),
            1'b1, SIDE_BACK);
    add_row(box_word(0, 0, C_MAX, 0, 0, C_MAX, 0, 0, 0, C_MAX, KIND_AXIAL_Z, 3'b111),
            1'b1, SIDE_FRONT);
    add_row(box_word(0, 0, C_MIN, 0, 0, C_MIN, 0, 0, 0, 0, KIND_AXIAL_Z, 3'b111),
            1'b1, SIDE_BACK);
    // An inverted box and a point box on an axial plane.
    add_row(box_word(10, 0, 0, 0, 0, 0, 0, 0, 0, 5, KIND_AXIAL_X, 3'b000), 1'b1, SIDE_FRONT);
    add_row(box_word(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, KIND_AXIAL_X, 3'b000), 1'b1, SIDE_FRONT);
    // General planes with a zero normal.
    add_row(box_word(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, KIND_GENERAL_0, 3'b000), 1'b1, SIDE_FRONT);
    add_row(box_word(0, 0, 0, 0, 0, 0, 0, 0, 0, 1, KIND_GENERAL_0, 3'b000), 1'b1, SIDE_BACK);
    // Inconsistent sign bit: the box touches neither side; then the same box with consistent signs.
    add_row(box_word(0, 0, 0, 131072, 0, 0, 16384, 0, 0, 65536, KIND_GENERAL_0, 3'b001),
            1'b1, SIDE_NONE);
    add_row(box_word(0, 0, 0, 131072, 0, 0, 16384, 0, 0, 65536, KIND_GENERAL_1, 3'b000),
            1'b1, SIDE_CROSS);
    add_row(box_word(0, 0, 0, 131072, 0, 0, 16384, 0, 0, -65536, KIND_GENERAL_2, 3'b000),
            1'b1, SIDE_FRONT);
    // Plane kinds six and seven behave as general planes.
    add_row(box_word(0, 0, 0, 131072, 0, 0, 16384, 0, 0, 196608, KIND_GENERAL_3, 3'b000),
            1'b1, SIDE_BACK);
    add_row(box_word(0, 0, 0, 131072, 0, 0, 16384, 0, 0, 65536, KIND_GENERAL_4, 3'b000),
            1'b1, SIDE_CROSS);
    // Extreme products and sums, checked against the predictor.
    add_row(box_word(C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX, 16'sh8000, 16'sh8000,
                     16'sh8000, C_MIN, KIND_GENERAL_0, 3'b111), 1'b0, SIDE_NONE);
    add_row(box_word(C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX, 16'sh7FFF, 16'sh7FFF,
                     16'sh7FFF, C_MAX, KIND_GENERAL_1, 3'b000), 1'b0, SIDE_NONE);
    add_row(box_word(C_MIN, 12345, C_MAX, C_MAX, 67890, C_MAX, 16'sh8000, 16'sh7FFF,
                     16'sh5555, 0, KIND_GENERAL_2, 3'b101), 1'b0, SIDE_NONE);
    add_row(box_word(100000, -5, 7, -100000, -9, 3, 8000, -8000, 12000, 1, KIND_GENERAL_3,
                     3'b010), 1'b0, SIDE_NONE);
    add_row(box_word(-1, -1, -1, -1, -1, -1, -1, -1, -1, -1, KIND_GENERAL_4, 3'b111),
            1'b0, SIDE_NONE);

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (side_rows[i]) begin
      send_word(side_rows[i].w, side_rows[i].typed ? side_rows[i].side
                                                   : predict_side(side_rows[i].w));
    end
    for (int i = 0; i < N_RANDOM; i++) begin
      quiet_tail = (i >= N_RANDOM - QUIET_TAIL);
      gen_test_word(w);
      send_word(w, predict_side(w));
    end
    in_ch.valid <= 1'b0;

    while (expected_sides.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && expected_sides.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Receiver: random stalls, one long hold-off that fills the pipeline, none at the tail.
  initial begin
    out_ch.ready = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (!long_hold_done && words_taken >= HOLD_AFTER) begin
        long_hold_done = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
      end else if (!quiet_tail && $urandom_range(0, 4) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk_i);
      end else begin
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk_i);
      end
    end
  end

  // Result check against the oldest outstanding side mask.
  always @(posedge clk_i) begin : side_check
    logic [SIDE_WIDTH-1:0] want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (expected_sides.size() == 0) begin
        report_mismatch("result with no word outstanding", out_ch.side_mask, SIDE_NONE);
      end else begin
        want = expected_sides.pop_front();
        if (out_ch.side_mask !== want) begin
          report_mismatch("side_mask", out_ch.side_mask, want);
        end
      end
    end
  end

  // Watchdog on cycles in which no word moves on either channel.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("watchdog: no word moved for %0d cycles", STALL_LIMIT);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

endmodule
